// ===== sv/pse_pkg.sv =====
// Shared types and constants for the polynomial store and evaluator.
package pse_pkg;

	localparam int KIND_W  = 2;
	localparam int EXP_W   = 4;
	localparam int DATA_W  = 32;
	localparam int DEG_W   = 3;
	localparam int COUNT_W = 4;

	localparam logic [KIND_W-1:0] KIND_WRITE = 2'd0;
	localparam logic [KIND_W-1:0] KIND_READ  = 2'd1;
	localparam logic [KIND_W-1:0] KIND_EVAL  = 2'd2;

	typedef enum logic [2:0] {
		ST_IDLE = 3'b001,
		ST_READ = 3'b010,
		ST_EVAL = 3'b100
	} state_t;

endpackage

// ===== sv/polynomial_store_evaluate.sv =====
// Coefficient store with term write, term read and polynomial evaluation.
//
// A transaction is taken when start is high and busy is low, and each one
// gives exactly one result, shown for a single cycle while done is high; the
// receiver cannot stall it. A term write, or an unused kind, returns its result
// in the cycle after acceptance and leaves busy low. A term read passes through
// the READ state, as the coefficient memory has a registered read port. An
// evaluation runs Horner's rule on one shared 32 by 32 multiply-accumulate
// unit, one coefficient per cycle, walking the memory from the highest
// exponent down. Writing the degree register starts a new, all-zero polynomial;
// it takes effect on the clock edge at which degree_we is high.
module polynomial_store_evaluate #(
	parameter int MAX_DEGREE = 7
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	output logic                          busy,
	input  logic [pse_pkg::KIND_W-1:0]    kind,
	input  logic [pse_pkg::EXP_W-1:0]     exponent,
	input  logic signed [pse_pkg::DATA_W-1:0] coef_value,
	input  logic signed [pse_pkg::DATA_W-1:0] x_value,
	input  logic                          degree_we,
	input  logic [pse_pkg::DEG_W-1:0]     degree_data,
	output logic                          done,
	output logic                          ok,
	output logic signed [pse_pkg::DATA_W-1:0] coef_out,
	output logic signed [pse_pkg::DATA_W-1:0] poly_value,
	output logic [pse_pkg::COUNT_W-1:0]   term_count
);
	import pse_pkg::*;

	localparam int DEPTH   = MAX_DEGREE + 1;
	localparam int AW      = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW      = $clog2(DEPTH + 1);
	localparam int DEG_CAP = (MAX_DEGREE > 7) ? 7 : MAX_DEGREE;

	// Coefficient memory; the nonzero flags double as its valid bits.
	logic [DATA_W-1:0] mem [DEPTH];
	logic [DEPTH-1:0]  nz_q;
	logic [CW-1:0]     count_q;
	logic [DEG_W-1:0]  degree_q;

	state_t            state_q;
	logic [AW-1:0]     cnt_q;
	logic [DATA_W-1:0] x_q;
	logic [DATA_W-1:0] acc_q;
	logic              in_range_q;

	logic [DATA_W-1:0] rd_data_q;
	logic              rd_nz_q;

	logic              done_q;
	logic              ok_q;
	logic [DATA_W-1:0] coef_out_q;
	logic [DATA_W-1:0] poly_q;

	logic [DEG_W-1:0]  deg_eff;
	logic              in_range;
	logic              accept;
	logic [AW-1:0]     exp_idx;
	logic [AW-1:0]     deg_idx;
	logic [AW-1:0]     rd_addr;
	logic [DATA_W-1:0] prod;
	logic [DATA_W-1:0] mac;

	assign deg_eff  = (degree_q > DEG_W'(DEG_CAP)) ? DEG_W'(DEG_CAP) : degree_q;
	assign in_range = exponent <= {1'b0, deg_eff};
	assign accept   = start && (state_q == ST_IDLE);
	assign exp_idx  = AW'(exponent);
	assign deg_idx  = AW'(deg_eff);

	always_comb begin
		if (state_q == ST_EVAL) begin
			rd_addr = cnt_q - 1'b1;
		end else if (kind == KIND_EVAL) begin
			rd_addr = deg_idx;
		end else begin
			rd_addr = exp_idx;
		end
	end

	// Shared multiply-accumulate: acc * x + coefficient, wrapping at 32 bits.
	assign prod = acc_q * x_q;
	assign mac  = prod + (rd_nz_q ? rd_data_q : '0);

	always_ff @(posedge clk) begin
		if (accept && kind == KIND_WRITE && in_range) begin
			mem[exp_idx] <= coef_value;
		end
		rd_data_q <= mem[rd_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			nz_q     <= '0;
			count_q  <= '0;
			degree_q <= '0;
			rd_nz_q  <= 1'b0;
		end else begin
			rd_nz_q <= nz_q[rd_addr];
			if (degree_we) begin
				degree_q <= degree_data;
				nz_q     <= '0;
				count_q  <= '0;
			end else if (accept && kind == KIND_WRITE && in_range) begin
				nz_q[exp_idx] <= coef_value != '0;
				if (coef_value != '0 && !nz_q[exp_idx]) begin
					count_q <= count_q + 1'b1;
				end else if (coef_value == '0 && nz_q[exp_idx]) begin
					count_q <= count_q - 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q   <= '0;
			done_q  <= 1'b0;
		end else begin
			done_q <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						if (kind == KIND_READ) begin
							state_q <= ST_READ;
						end else if (kind == KIND_EVAL) begin
							state_q <= ST_EVAL;
							cnt_q   <= deg_idx;
						end else begin
							done_q <= 1'b1;
						end
					end
				end
				ST_READ: begin
					state_q <= ST_IDLE;
					done_q  <= 1'b1;
				end
				ST_EVAL: begin
					if (cnt_q == '0) begin
						state_q <= ST_IDLE;
						done_q  <= 1'b1;
					end else begin
						cnt_q <= cnt_q - 1'b1;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Payload registers of the result and the evaluation datapath.
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					in_range_q <= in_range;
					x_q        <= x_value;
					acc_q      <= '0;
					ok_q       <= (kind == KIND_WRITE) && in_range;
					coef_out_q <= '0;
					poly_q     <= '0;
				end
			end
			ST_READ: begin
				ok_q       <= in_range_q && rd_nz_q;
				coef_out_q <= (in_range_q && rd_nz_q) ? rd_data_q : '0;
			end
			ST_EVAL: begin
				acc_q <= mac;
				if (cnt_q == '0) begin
					ok_q   <= 1'b1;
					poly_q <= mac;
				end
			end
			default: begin
				ok_q <= 1'b0;
			end
		endcase
	end

	assign busy       = state_q != ST_IDLE;
	assign done       = done_q;
	assign ok         = ok_q;
	assign coef_out   = coef_out_q;
	assign poly_value = poly_q;
	assign term_count = COUNT_W'(count_q);

	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy)
		else $error("result strobe while the sequencer is still running");

	a_one_result: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> (done || busy))
		else $error("accepted transaction produced neither a result nor work");

	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(DEPTH))
		else $error("nonzero term count exceeds the store depth");

	a_count_flags: assert property (@(posedge clk) disable iff (!arst_n)
		(count_q == '0) == (nz_q == '0))
		else $error("term count disagrees with the nonzero flags");

	a_fail_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(done && !ok) |-> (coef_out == '0 && poly_value == '0))
		else $error("rejected transaction returned nonzero data");

endmodule

// ===== verif/polynomial_store_evaluate_checker.sv =====
// Checker for the polynomial store: mirrors the coefficients and scores every result.
module polynomial_store_evaluate_checker #(
	parameter int MAX_DEGREE = 7
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              start,
	input  logic                              busy,
	input  logic [pse_pkg::KIND_W-1:0]        kind,
	input  logic [pse_pkg::EXP_W-1:0]         exponent,
	input  logic signed [pse_pkg::DATA_W-1:0] coef_value,
	input  logic signed [pse_pkg::DATA_W-1:0] x_value,
	input  logic                              degree_we,
	input  logic [pse_pkg::DEG_W-1:0]         degree_data,
	input  logic                              done,
	input  logic                              ok,
	input  logic signed [pse_pkg::DATA_W-1:0] coef_out,
	input  logic signed [pse_pkg::DATA_W-1:0] poly_value,
	input  logic [pse_pkg::COUNT_W-1:0]       term_count,
	output int unsigned                       errors,
	output int                                pending
);
	import pse_pkg::*;

	typedef struct {
		logic                ok;
		logic [DATA_W-1:0]   coef_out;
		logic [DATA_W-1:0]   poly_value;
		logic [COUNT_W-1:0]  term_count;
	} reply_t;

	logic [DATA_W-1:0]  coef_mirror [0:MAX_DEGREE];
	logic [COUNT_W-1:0] nonzero_mirror;
	logic [DEG_W-1:0]   degree_mirror;
	reply_t             awaited_replies [$];

	function automatic void clear_mirror();
		for (int i = 0; i <= MAX_DEGREE; i++)
			coef_mirror[i] = '0;
		nonzero_mirror = '0;
	endfunction

	function automatic reply_t predict_reply(input logic [KIND_W-1:0] k,
			input logic [EXP_W-1:0] e, input logic [DATA_W-1:0] c,
			input logic [DATA_W-1:0] x);
		reply_t            r;
		int                top_exp;
		logic [DATA_W-1:0] power;
		r.ok = 1'b0;
		r.coef_out = '0;
		r.poly_value = '0;
		top_exp = (int'(degree_mirror) > MAX_DEGREE) ? MAX_DEGREE : int'(degree_mirror);
		case (k)
			KIND_WRITE: begin
				if (int'(e) <= top_exp) begin
					if (c == '0 && coef_mirror[e] != '0)
						nonzero_mirror = nonzero_mirror - 1'b1;
					else if (c != '0 && coef_mirror[e] == '0)
						nonzero_mirror = nonzero_mirror + 1'b1;
					coef_mirror[e] = c;
					r.ok = 1'b1;
				end
			end
			KIND_READ: begin
				if (int'(e) <= top_exp && coef_mirror[e] != '0) begin
					r.coef_out = coef_mirror[e];
					r.ok = 1'b1;
				end
			end
			KIND_EVAL: begin
				// Plain power series; every product and sum wraps at 32 bits.
				power = 32'd1;
				for (int i = 0; i <= top_exp; i++) begin
					r.poly_value = r.poly_value + coef_mirror[i] * power;
					power = power * x;
				end
				r.ok = 1'b1;
			end
			default: ;
		endcase
		r.term_count = nonzero_mirror;
		return r;
	endfunction

	task automatic check_field(input string name, input logic [DATA_W-1:0] want,
			input logic [DATA_W-1:0] got);
		if (got !== want) begin
			errors++;
			$display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		reply_t want;
		if (!arst_n) begin
			clear_mirror();
			degree_mirror = '0;
			awaited_replies.delete();
		end else begin
			// The oldest result is scored before any transaction taken at this edge is queued.
			if (done) begin
				if (awaited_replies.size() == 0) begin
					errors++;
					$display("%0t: result with none expected, actual ok=%b coef=%h value=%h count=%0d",
						$time, ok, coef_out, poly_value, term_count);
				end else begin
					want = awaited_replies.pop_front();
					check_field("ok", 32'(want.ok), 32'(ok));
					check_field("coef_out", want.coef_out, coef_out);
					check_field("poly_value", want.poly_value, poly_value);
					check_field("term_count", 32'(want.term_count), 32'(term_count));
				end
			end
			if (degree_we) begin
				degree_mirror = degree_data;
				clear_mirror();
			end
			if (start && !busy)
				awaited_replies.push_back(predict_reply(kind, exponent, coef_value, x_value));
		end
		pending = awaited_replies.size();
	end

endmodule

// ===== verif/polynomial_store_evaluate_tb.sv =====
// Testbench top for the polynomial store: stimulus, watchdog and verdict.
module polynomial_store_evaluate_tb;
	import pse_pkg::*;

	localparam int                MAX_DEG      = 7;
	localparam int                RANDOM_ITEMS = 550;
	localparam int                IDLE_LIMIT   = 2000;
	localparam logic [KIND_W-1:0] KIND_SPARE   = 2'd3;

	logic                     clk;
	logic                     arst_n;
	logic                     start;
	logic                     busy;
	logic [KIND_W-1:0]        kind;
	logic [EXP_W-1:0]         exponent;
	logic signed [DATA_W-1:0] coef_value;
	logic signed [DATA_W-1:0] x_value;
	logic                     degree_we;
	logic [DEG_W-1:0]         degree_data;
	logic                     done;
	logic                     ok;
	logic signed [DATA_W-1:0] coef_out;
	logic signed [DATA_W-1:0] poly_value;
	logic [COUNT_W-1:0]       term_count;
	int unsigned              errors;
	int                       pending;
	int                       idle_cycles;
	int                       cur_degree;

	polynomial_store_evaluate #(.MAX_DEGREE(MAX_DEG)) u_top (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.kind(kind), .exponent(exponent), .coef_value(coef_value), .x_value(x_value),
		.degree_we(degree_we), .degree_data(degree_data),
		.done(done), .ok(ok), .coef_out(coef_out), .poly_value(poly_value),
		.term_count(term_count)
	);

	polynomial_store_evaluate_checker #(.MAX_DEGREE(MAX_DEG)) u_checker (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.kind(kind), .exponent(exponent), .coef_value(coef_value), .x_value(x_value),
		.degree_we(degree_we), .degree_data(degree_data),
		.done(done), .ok(ok), .coef_out(coef_out), .poly_value(poly_value),
		.term_count(term_count), .errors(errors), .pending(pending)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// Any cycle in which no transaction is taken counts towards the limit.
	always @(posedge clk) begin
		if (!arst_n)
			idle_cycles <= 0;
		else if (start && !busy)
			idle_cycles <= 0;
		else begin
			idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("polynomial_store_evaluate_tb NOT OK");
				$finish;
			end
		end
	end

	task automatic send_item(input logic [KIND_W-1:0] k, input logic [EXP_W-1:0] e,
			input logic [DATA_W-1:0] c, input logic [DATA_W-1:0] x);
		logic free;
		start <= 1'b1;
		kind <= k;
		exponent <= e;
		coef_value <= c;
		x_value <= x;
		// Busy is looked at mid-cycle, where it cannot be changing.
		do begin
			@(negedge clk);
			free = !busy;
			@(posedge clk);
		end while (!free);
	endtask

	task automatic pause(input int cycles);
		if (cycles > 0) begin
			start <= 1'b0;
			repeat (cycles) @(posedge clk);
		end
	endtask

	task automatic set_degree(input logic [DEG_W-1:0] d);
		start <= 1'b0;
		do @(negedge clk); while (pending != 0);
		repeat (2) @(posedge clk);
		degree_we <= 1'b1;
		degree_data <= d;
		cur_degree = d;
		@(posedge clk);
		degree_we <= 1'b0;
	endtask

	function automatic logic [DATA_W-1:0] pick_word();
		case ($urandom_range(0, 9))
			0: return 32'h0000_0000;
			1: return 32'h7FFF_FFFF;
			2: return 32'h8000_0000;
			3: return 32'hFFFF_FFFF;
			4: return 32'h0000_0001;
			5: return 32'($signed($urandom_range(0, 15)) - 8);
			default: return $urandom;
		endcase
	endfunction

	initial begin
		int             counted;
		int             next_switch;
		int             phase;
		int             burst;
		int             pick;
		logic [KIND_W-1:0] k;
		logic [EXP_W-1:0]  e;
		logic [DATA_W-1:0] c;
		arst_n = 1'b0;
		start = 1'b0;
		kind = KIND_WRITE;
		exponent = '0;
		coef_value = '0;
		x_value = '0;
		degree_we = 1'b0;
		degree_data = '0;
		cur_degree = 0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Degree zero straight after reset: only the constant term is live.
		send_item(KIND_READ, 4'd0, 32'h0, 32'h0);
		send_item(KIND_EVAL, 4'd0, 32'h0, 32'd5);
		send_item(KIND_WRITE, 4'd1, 32'd5, 32'h0);
		send_item(KIND_WRITE, 4'd0, 32'h7FFF_FFFF, 32'h0);
		send_item(KIND_READ, 4'd0, 32'h0, 32'h0);
		send_item(KIND_EVAL, 4'd0, 32'h0, 32'h8000_0000);
		send_item(KIND_SPARE, 4'd0, 32'h1234_5678, 32'h9ABC_DEF0);
		set_degree(3'd7);
		send_item(KIND_WRITE, 4'd15, 32'd1, 32'h0);
		send_item(KIND_WRITE, 4'd7, 32'h8000_0000, 32'h0);
		send_item(KIND_WRITE, 4'd0, 32'hFFFF_FFFF, 32'h0);
		send_item(KIND_WRITE, 4'd3, 32'd12345, 32'h0);
		send_item(KIND_WRITE, 4'd3, 32'h0, 32'h0);
		send_item(KIND_WRITE, 4'd3, 32'h0, 32'h0);
		send_item(KIND_READ, 4'd3, 32'h0, 32'h0);
		send_item(KIND_READ, 4'd8, 32'h0, 32'h0);
		send_item(KIND_READ, 4'd7, 32'h0, 32'h0);
		send_item(KIND_EVAL, 4'd0, 32'h0, 32'h7FFF_FFFF);
		send_item(KIND_EVAL, 4'd0, 32'h0, 32'hFFFF_FFFF);
		send_item(KIND_EVAL, 4'd0, 32'h0, 32'h0);
		send_item(KIND_EVAL, 4'd0, 32'h0, 32'd2);
		send_item(KIND_SPARE, 4'd15, 32'hFFFF_FFFF, 32'hFFFF_FFFF);

		counted = 0;
		next_switch = 0;
		phase = 0;
		while (counted < RANDOM_ITEMS) begin
			if (counted >= next_switch) begin
				case (phase)
					0: set_degree(3'd7);
					1: set_degree(3'd0);
					default: set_degree(3'($urandom_range(0, 7)));
				endcase
				phase++;
				next_switch = counted + $urandom_range(50, 90);
			end
			// Mostly short bursts, now and then a long one with no gaps at all.
			burst = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 40) : $urandom_range(1, 8);
			repeat (burst) begin
				pick = $urandom_range(0, 99);
				if (pick < 40)
					k = KIND_WRITE;
				else if (pick < 62)
					k = KIND_READ;
				else if (pick < 95)
					k = KIND_EVAL;
				else
					k = KIND_SPARE;
				e = ($urandom_range(0, 99) < 85) ? 4'($urandom_range(0, cur_degree))
					: 4'($urandom_range(0, 15));
				c = ($urandom_range(0, 9) == 0) ? 32'h0 : pick_word();
				send_item(k, e, c, pick_word());
				if (k != KIND_SPARE)
					counted++;
			end
			pause(($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 15));
		end

		start <= 1'b0;
		do @(negedge clk); while (pending != 0);
		repeat (12) @(posedge clk);
		if (errors == 0 && pending == 0)
			$display("polynomial_store_evaluate_tb OK");
		else
			$display("polynomial_store_evaluate_tb NOT OK");
		$finish;
	end

endmodule

// ===== filelist.f =====
sv/pse_pkg.sv
sv/polynomial_store_evaluate.sv
verif/polynomial_store_evaluate_checker.sv
verif/polynomial_store_evaluate_tb.sv
